### sv/solenoid_pulse_scheduler_assert.svh
// Assertion macros shared by the checker of the solenoid pulse scheduler.
`ifndef SOLENOID_PULSE_SCHEDULER_ASSERT_SVH
`define SOLENOID_PULSE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sps_pkg.sv
// Package with the codes and constants of the solenoid pulse scheduler.
package sps_pkg;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_RR     = 2'd1;
   localparam logic [1:0] REQ_DIRECT = 2'd2;

   localparam logic [1:0] CSR_PULSE_TICKS = 2'd0;
   localparam logic [1:0] CSR_DUTY_FLOOR  = 2'd1;
   localparam logic [1:0] CSR_DUTY_SPAN   = 2'd2;

   localparam logic [9:0] PULSE_TICKS_RESET = 10'd25;
   localparam logic [7:0] DUTY_FLOOR_RESET  = 8'd205;
   localparam logic [7:0] DUTY_SPAN_RESET   = 8'd50;

   localparam logic [9:0] RR_CHUNK      = 10'd85;
   localparam logic [9:0] RR_MAX        = 10'd765;
   localparam logic [9:0] STRENGTH_FULL = 10'd255;

endpackage

### sv/sps_cnt_mem.sv
// Countdown memory: one write port and one registered read port.
module sps_cnt_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [9:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [9:0]    rd_data
);

   logic [9:0] cnt_mem_ff [DEPTH];
   logic [9:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cnt_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sps_duty.sv
// Duty calculation: floor plus strength times span over 255, saturated.
module sps_duty (
   input  logic [7:0] strength,
   input  logic [7:0] duty_floor,
   input  logic [7:0] duty_span,
   output logic [7:0] duty
);

   logic [15:0] prod;
   logic [15:0] recip_sum;
   logic [7:0]  quot;
   logic [8:0]  total;

   // Exact division by 255 for any product of two 8-bit values.
   assign prod      = {8'b0, strength} * {8'b0, duty_span};
   assign recip_sum = 16'(prod + {8'b0, prod[15:8]} + 16'd1);
   assign quot      = recip_sum[15:8];
   assign total     = {1'b0, duty_floor} + {1'b0, quot};
   assign duty      = total[8] ? 8'hFF : total[7:0];

endmodule

### sv/solenoid_pulse_scheduler.sv
// Top level of the solenoid pulse scheduler: request sequencer and result register.
// A tick walks the countdown memory through its single read port, one channel per cycle
// while no expiry waits for a full output register. A direct tap gives one result; a
// round-robin tap gives one result per chunk (up to 9). Each result is registered in
// the output register and waits there while rsp_tready is low.
// Synchronous reset clears the valid bits, rotation and result flag; CSRs get defaults.
module solenoid_pulse_scheduler #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [2:0] channel, [12:3] strength, [15:13] zero
   input  logic [1:0]  req_tuser,  // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [2:0] out_channel, [10:3] duty, [15:11] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   import sps_pkg::*;

   localparam int CW = $clog2(NUM_CHANNELS);
   localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);
   localparam logic [CW-1:0] RR_WRAP = CW'(NUM_CHANNELS - 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_TAP  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [9:0]              s_rem_ff, s_rem_in;
   logic                    is_rr_ff, is_rr_in;
   logic [CW-1:0]           cmd_ch_ff, cmd_ch_in;
   logic [CW-1:0]           rr_ff, rr_in;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [NUM_CHANNELS-1:0] exp_ff, exp_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_ch_ff, rsp_ch_in;
   logic [7:0]              rsp_duty_ff, rsp_duty_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [9:0]              pulse_ticks_ff, pulse_ticks_in;
   logic [7:0]              duty_floor_ff, duty_floor_in;
   logic [7:0]              duty_span_ff, duty_span_in;

   logic                    req_accept;
   logic                    out_free;
   logic [2:0]              in_ch;
   logic [9:0]              in_s;
   logic [9:0]              rr_s_sat;
   logic [CW-1:0]           in_ch_clamped;

   logic                    mem_wr_en;
   logic [CW-1:0]           mem_wr_addr;
   logic [9:0]              mem_wr_data;
   logic                    mem_rd_en;
   logic [CW-1:0]           mem_rd_addr;
   logic [9:0]              mem_rd_data;

   logic [9:0]              old_cnt;
   logic [9:0]              new_cnt;
   logic                    running;
   logic                    expire;
   logic                    tick_go;
   logic [NUM_CHANNELS-1:0] exp_above;
   logic                    tick_last;

   logic [6:0]              chunk;
   logic [7:0]              rr_str;
   logic [7:0]              dir_str;
   logic [7:0]              tap_str;
   logic [CW-1:0]           tap_ch;
   logic                    tap_last;
   logic [7:0]              tap_duty;

   sps_cnt_mem #(
      .DEPTH (NUM_CHANNELS),
      .AW    (CW)
   ) u_cnt_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sps_duty u_duty (
      .strength   (tap_str),
      .duty_floor (duty_floor_ff),
      .duty_span  (duty_span_ff),
      .duty       (tap_duty)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_ch      = req_tdata[2:0];
   assign in_s       = req_tdata[12:3];
   assign rr_s_sat   = (in_s > RR_MAX) ? RR_MAX : in_s;

   assign in_ch_clamped = ({2'b0, in_ch} >= 5'(NUM_CHANNELS)) ? LAST_CH : CW'(in_ch);

   // Tick scan of the entry read in the previous cycle.
   assign old_cnt   = rd_valid_ff ? mem_rd_data : 10'd0;
   assign new_cnt   = old_cnt - 10'd1;
   assign running   = (old_cnt != 10'd0);
   assign expire    = (old_cnt == 10'd1);
   assign tick_go   = !expire || out_free;
   assign exp_above = exp_ff >> idx_ff;
   assign tick_last = ~|exp_above[NUM_CHANNELS-1:1];

   // Tap of one chunk or of the direct channel.
   assign chunk    = (s_rem_ff > RR_CHUNK) ? RR_CHUNK[6:0] : s_rem_ff[6:0];
   assign rr_str   = 8'({1'b0, chunk}) + 8'({chunk, 1'b0});
   assign dir_str  = (s_rem_ff > STRENGTH_FULL) ? STRENGTH_FULL[7:0] : s_rem_ff[7:0];
   assign tap_str  = is_rr_ff ? rr_str : dir_str;
   assign tap_ch   = is_rr_ff ? CW'(rr_ff + 1'b1) : cmd_ch_ff;
   assign tap_last = !is_rr_ff || (s_rem_ff <= RR_CHUNK);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      s_rem_in     = s_rem_ff;
      is_rr_in     = is_rr_ff;
      cmd_ch_in    = cmd_ch_ff;
      rr_in        = rr_ff;
      valid_in     = valid_ff;
      exp_in       = exp_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = new_cnt;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  REQ_TICK: begin
                     state_in    = ST_TICK;
                     idx_in      = '0;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     rd_valid_in = valid_ff[0];
                  end
                  REQ_RR: begin
                     if (rr_s_sat != 10'd0) begin
                        state_in = ST_TAP;
                        is_rr_in = 1'b1;
                        s_rem_in = rr_s_sat;
                     end
                  end
                  REQ_DIRECT: begin
                     state_in  = ST_TAP;
                     is_rr_in  = 1'b0;
                     s_rem_in  = in_s;
                     cmd_ch_in = in_ch_clamped;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (tick_go) begin
               if (running) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_addr    = idx_ff;
                  mem_wr_data    = new_cnt;
                  exp_in[idx_ff] = (old_cnt == 10'd2);
               end
               if (expire) begin
                  rsp_valid_in = 1'b1;
                  rsp_ch_in    = 3'(idx_ff);
                  rsp_duty_in  = 8'd0;
                  rsp_last_in  = tick_last;
               end
               if (idx_ff == LAST_CH) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = CW'(idx_ff + 1'b1);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = CW'(idx_ff + 1'b1);
                  rd_valid_in = valid_ff[CW'(idx_ff + 1'b1)];
               end
            end
         end
         ST_TAP: begin
            if (out_free) begin
               mem_wr_en        = 1'b1;
               mem_wr_addr      = tap_ch;
               mem_wr_data      = pulse_ticks_ff;
               valid_in[tap_ch] = 1'b1;
               exp_in[tap_ch]   = (pulse_ticks_ff == 10'd1);
               rsp_valid_in     = 1'b1;
               rsp_ch_in        = 3'(tap_ch);
               rsp_duty_in      = tap_duty;
               rsp_last_in      = tap_last;
               if (is_rr_ff) begin
                  s_rem_in = s_rem_ff - {3'b0, chunk};
                  rr_in    = (rr_ff == RR_WRAP) ? '0 : CW'(rr_ff + 1'b1);
               end
               if (tap_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   always_comb begin
      pulse_ticks_in = pulse_ticks_ff;
      duty_floor_in  = duty_floor_ff;
      duty_span_in   = duty_span_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE_TICKS: pulse_ticks_in = csr_data;
            CSR_DUTY_FLOOR:  duty_floor_in  = csr_data[7:0];
            CSR_DUTY_SPAN:   duty_span_in   = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rr_ff          <= '0;
         valid_ff       <= '0;
         exp_ff         <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pulse_ticks_ff <= PULSE_TICKS_RESET;
         duty_floor_ff  <= DUTY_FLOOR_RESET;
         duty_span_ff   <= DUTY_SPAN_RESET;
      end else begin
         state_ff       <= state_in;
         rr_ff          <= rr_in;
         valid_ff       <= valid_in;
         exp_ff         <= exp_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pulse_ticks_ff <= pulse_ticks_in;
         duty_floor_ff  <= duty_floor_in;
         duty_span_ff   <= duty_span_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      s_rem_ff    <= s_rem_in;
      is_rr_ff    <= is_rr_in;
      cmd_ch_ff   <= cmd_ch_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_duty_ff, rsp_ch_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/sps_checker.sv
// Port-level assertion checker for the solenoid pulse scheduler, with its bind.
`include "solenoid_pulse_scheduler_assert.svh"

module sps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   import sps_pkg::*;

   logic busy_req;

   // A tick, a direct tap or a nonzero round-robin tap occupies the sequencer.
   assign busy_req = req_tvalid && req_tready &&
                     ((req_tuser == REQ_TICK) || (req_tuser == REQ_DIRECT) ||
                      ((req_tuser == REQ_RR) && (req_tdata[12:3] != 10'd0)));

   `SPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "Result item changed while stalled.")
   `SPS_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "Result item shown right after reset.")
   `SPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, busy_req, !req_tready, "Request accepted while previous item still in work.")
   `SPS_ASSERT_NEXT(a_direct_result, clock, reset, req_tvalid && req_tready && (req_tuser == REQ_DIRECT) && !rsp_tvalid, !rsp_tvalid && !req_tready, "Direct tap result appeared too early.")

endmodule

bind solenoid_pulse_scheduler sps_checker u_sps_checker (.*);
